// ----- design/kmsw_pkg.sv -----
package kmsw_pkg;
   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_MEDOID = 2'd1;
   localparam logic [1:0] KIND_RUN = 2'd2;
   localparam logic CSR_POINTS = 1'b0;
   localparam logic CSR_MEDOIDS = 1'b1;

   typedef struct packed {
      logic [1:0] kind;
      logic [5:0] row;
      logic [5:0] col;
      logic [15:0] distance;
      logic [2:0] medoid_slot;
      logic [5:0] initial_point;
   } req_type;

   typedef struct packed {
      logic [5:0] point_index;
      logic [2:0] cluster_slot;
      logic [5:0] assigned_medoid;
      logic [5:0] slot_medoid;
      logic [21:0] total_cost;
      logic error;
      logic last;
   } rsp_type;
endpackage

// ----- design/kmsw_if.sv -----
interface kmsw_req_if;
   import kmsw_pkg::*;
   logic valid;
   logic ready;
   req_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

interface kmsw_rsp_if;
   import kmsw_pkg::*;
   logic valid;
   logic ready;
   rsp_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

// ----- design/k_medoids_swap_search.sv -----
// Channel  Dir  Word
// req      in   kind, row, col, distance, medoid_slot, initial_point
// rsp      out  point_index, cluster_slot, assigned_medoid, slot_medoid, total_cost,
//               error, last
// Load words are taken in ST_IDLE. A run walks the distance memory one entry at a time
// (one read port, request then data state): assignment reads n*k entries and every swap
// pass up to k*n*n; each result word then passes through ST_OREQ and ST_OSHOW.
// Reset is synchronous and clears control state only; the memories need no clearing.
// A run holds req.ready low until its last result word has been taken.
module k_medoids_swap_search #(
   parameter int MAX_POINTS = 64,
   parameter int MAX_CLUSTERS = 8,
   parameter int DIST_BITS = 16
) (
   input logic clock,
   input logic reset,
   kmsw_req_if.sink req,
   kmsw_rsp_if.source rsp,
   input logic csr_write_enable,
   input logic csr_index,
   input logic [6:0] csr_write_data
);
   import kmsw_pkg::*;

   localparam int PW = $clog2(MAX_POINTS);
   localparam int SW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
   localparam int NW = $clog2(MAX_POINTS + 1);
   localparam int KW = $clog2(MAX_CLUSTERS + 1);
   localparam int CW = DIST_BITS + PW + 2;
   localparam int DEPTH = 2 ** (2 * PW);
   localparam logic [DIST_BITS:0] INF = '1;

   localparam logic [3:0] ST_IDLE = 4'd0, ST_AREQ = 4'd1, ST_ADAT = 4'd2,
      ST_SREQ = 4'd3, ST_SDAT = 4'd4, ST_SNEXT = 4'd5, ST_APPLY = 4'd6,
      ST_OREQ = 4'd7, ST_OSHOW = 4'd8, ST_ERR = 4'd9, ST_DRAIN = 4'd10;

   // The distance memory is addressed by {row, col}.
   logic [DIST_BITS-1:0] dmem [DEPTH];
   logic [PW-1:0] med_ff [MAX_CLUSTERS];
   logic [SW-1:0] nslot_mem [MAX_POINTS];
   logic [DIST_BITS-1:0] ndist_mem [MAX_POINTS];
   logic [DIST_BITS:0] sdist_mem [MAX_POINTS];

   logic [6:0] npts_ff;
   logic [3:0] nmed_ff;
   logic [3:0] state_ff;
   logic [PW:0] i_ff;
   logic [SW:0] s_ff;
   logic [PW:0] c_ff;
   logic [DIST_BITS:0] best_ff, second_ff;
   logic [SW-1:0] bslot_ff;
   logic signed [CW-1:0] cost_ff, delta_ff, bdelta_ff;
   logic [SW-1:0] wslot_ff;
   logic [PW-1:0] wcand_ff;
   logic [DIST_BITS-1:0] rd_ff;
   logic [SW-1:0] rnslot_ff;
   logic [DIST_BITS-1:0] rndist_ff;
   logic [DIST_BITS:0] rsdist_ff;
   logic ismed_ff;
   logic rsp_valid_ff;
   rsp_type rsp_word_ff;

   logic [NW-1:0] n_eff;
   logic [KW-1:0] k_eff;
   logic [PW-1:0] i_idx, c_idx;
   logic [SW-1:0] s_idx;
   logic [PW-1:0] rd_row, rd_col;
   logic cand_is_med;

   assign n_eff = (32'(npts_ff) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(npts_ff);
   assign k_eff = (32'(nmed_ff) > MAX_CLUSTERS) ? KW'(MAX_CLUSTERS) : KW'(nmed_ff);
   assign i_idx = i_ff[PW-1:0];
   assign c_idx = c_ff[PW-1:0];
   assign s_idx = s_ff[SW-1:0];

   always_comb begin
      cand_is_med = 1'b0;
      for (int m = 0; m < MAX_CLUSTERS; m++) begin
         if (m < 32'(k_eff) && med_ff[m] == c_idx) cand_is_med = 1'b1;
      end
   end

   assign rd_row = i_idx;
   assign rd_col = (state_ff == ST_AREQ) ? med_ff[s_idx] : c_idx;

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.word = rsp_word_ff;

   always_ff @(posedge clock) begin
      if (req.valid && req.ready && req.word.kind == KIND_WRITE &&
          32'(req.word.row) < MAX_POINTS && 32'(req.word.col) < MAX_POINTS)
         dmem[{PW'(req.word.row), PW'(req.word.col)}] <= DIST_BITS'(req.word.distance);
      rd_ff <= dmem[{rd_row, rd_col}];
      rnslot_ff <= nslot_mem[i_idx];
      rndist_ff <= ndist_mem[i_idx];
      rsdist_ff <= sdist_mem[i_idx];
      ismed_ff <= cand_is_med;
   end

   // Per-point candidate contribution to the swap delta.
   logic [DIST_BITS:0] dc, nd;
   logic signed [CW-1:0] contrib;
   always_comb begin
      dc = {1'b0, rd_ff};
      nd = (dc < rsdist_ff) ? dc : rsdist_ff;
      contrib = '0;
      if (rnslot_ff == s_idx)
         contrib = CW'(nd) - CW'(rndist_ff);
      else if (rd_ff < rndist_ff)
         contrib = CW'(rd_ff) - CW'(rndist_ff);
   end

   logic [DIST_BITS:0] dd;
   assign dd = {1'b0, rd_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         npts_ff <= 7'd64;
         nmed_ff <= 4'd2;
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         wslot_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_POINTS) npts_ff <= csr_write_data;
            else nmed_ff <= csr_write_data[3:0];
         end
         case (state_ff)
            ST_IDLE: begin
               if (req.valid) begin
                  if (req.word.kind == KIND_MEDOID && 32'(req.word.medoid_slot) <
                      MAX_CLUSTERS && 32'(req.word.initial_point) < MAX_POINTS)
                     med_ff[SW'(req.word.medoid_slot)] <= PW'(req.word.initial_point);
                  if (req.word.kind == KIND_RUN) begin
                     if (k_eff == '0 || 32'(k_eff) > 32'(n_eff)) begin
                        state_ff <= ST_ERR;
                     end else begin
                        i_ff <= '0;
                        s_ff <= '0;
                        best_ff <= INF;
                        second_ff <= INF;
                        bslot_ff <= '0;
                        cost_ff <= '0;
                        state_ff <= ST_AREQ;
                     end
                  end
               end
            end
            ST_AREQ: state_ff <= ST_ADAT;
            ST_ADAT: begin
               if (dd < best_ff) begin
                  second_ff <= best_ff;
                  best_ff <= dd;
                  bslot_ff <= s_idx;
               end else if (dd < second_ff) second_ff <= dd;
               state_ff <= ST_AREQ;
               if (32'(s_ff) + 1 >= 32'(k_eff)) begin
                  nslot_mem[i_idx] <= (dd < best_ff) ? s_idx : bslot_ff;
                  ndist_mem[i_idx] <= (dd < best_ff) ? rd_ff : best_ff[DIST_BITS-1:0];
                  sdist_mem[i_idx] <= (dd < best_ff) ? best_ff :
                     ((dd < second_ff) ? dd : second_ff);
                  cost_ff <= cost_ff + CW'((dd < best_ff) ? dd : best_ff);
                  s_ff <= '0;
                  best_ff <= INF;
                  second_ff <= INF;
                  bslot_ff <= '0;
                  i_ff <= i_ff + 1'b1;
                  if (32'(i_ff) + 1 >= 32'(n_eff)) begin
                     i_ff <= '0;
                     c_ff <= '0;
                     delta_ff <= '0;
                     bdelta_ff <= '0;
                     state_ff <= ST_SREQ;
                  end
               end else s_ff <= s_ff + 1'b1;
            end
            ST_SREQ: state_ff <= ST_SDAT;
            ST_SDAT: begin
               if (ismed_ff) begin
                  state_ff <= ST_SNEXT;
               end else begin
                  delta_ff <= delta_ff + contrib;
                  i_ff <= i_ff + 1'b1;
                  state_ff <= ST_SREQ;
                  if (32'(i_ff) + 1 >= 32'(n_eff)) begin
                     if (delta_ff + contrib < bdelta_ff) begin
                        bdelta_ff <= delta_ff + contrib;
                        wslot_ff <= s_idx;
                        wcand_ff <= c_idx;
                     end
                     state_ff <= ST_SNEXT;
                  end
               end
            end
            ST_SNEXT: begin
               i_ff <= '0;
               delta_ff <= '0;
               state_ff <= ST_SREQ;
               if (32'(c_ff) + 1 >= 32'(n_eff)) begin
                  c_ff <= '0;
                  s_ff <= s_ff + 1'b1;
                  if (32'(s_ff) + 1 >= 32'(k_eff)) state_ff <= ST_APPLY;
               end else c_ff <= c_ff + 1'b1;
            end
            ST_APPLY: begin
               i_ff <= '0;
               s_ff <= '0;
               if (bdelta_ff < 0) begin
                  med_ff[wslot_ff] <= wcand_ff;
                  best_ff <= INF;
                  second_ff <= INF;
                  bslot_ff <= '0;
                  cost_ff <= '0;
                  state_ff <= ST_AREQ;
               end else state_ff <= ST_OREQ;
            end
            ST_OREQ: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff <= ST_OSHOW;
               end
            end
            ST_OSHOW: begin
               rsp_valid_ff <= 1'b1;
               rsp_word_ff.point_index <= 6'(i_ff);
               rsp_word_ff.cluster_slot <= 3'(rnslot_ff);
               rsp_word_ff.assigned_medoid <= 6'(med_ff[rnslot_ff]);
               rsp_word_ff.slot_medoid <= (32'(i_ff) < 32'(k_eff)) ?
                  6'(med_ff[SW'(i_ff)]) : 6'd0;
               rsp_word_ff.total_cost <= 22'(cost_ff);
               rsp_word_ff.error <= 1'b0;
               rsp_word_ff.last <= (32'(i_ff) + 1 == 32'(n_eff));
               i_ff <= i_ff + 1'b1;
               state_ff <= (32'(i_ff) + 1 >= 32'(n_eff)) ? ST_DRAIN : ST_OREQ;
            end
            ST_ERR: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_word_ff <= '0;
                  rsp_word_ff.error <= 1'b1;
                  rsp_word_ff.last <= 1'b1;
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               // Wait until the final word is taken.
               if (rsp.ready || !rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               rsp_valid_ff <= 1'b0;
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> !rsp_valid_ff) else $error("ready while a result is pending");
   a_cost_nonneg: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OSHOW |-> cost_ff >= 0) else $error("negative total cost");
   a_bdelta: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SDAT |-> bdelta_ff <= 0) else $error("best delta above zero");
`endif
endmodule
